>>> hdl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants for the ray/sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int H_W           = 53;   // d.(o-c), exact

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd3;

  typedef struct packed {
    logic signed [31:0] o_x;
    logic signed [31:0] o_y;
    logic signed [31:0] o_z;
    logic signed [17:0] d_x;
    logic signed [17:0] d_y;
    logic signed [17:0] d_z;
  } rsi_ray_t;

  // sideband carried alongside the square root
  typedef struct packed {
    rsi_ray_t              ray;
    logic signed [H_W-1:0] h;
    logic                  miss;
  } rsi_side_t;

  typedef struct packed {
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic        [30:0] rad;
  } rsi_cfg_t;

endpackage

>>> hdl/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front
// Quadratic setup: h = d.(o-c), C = |o-c|^2 - r^2, discriminant h^2 - C.
// ----------------------------------------------------------------------------
module rsi_front #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF,
  parameter int DW        = 106
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  rsi_pkg::rsi_cfg_t   cfg,
  input  logic                in_v,
  input  rsi_pkg::rsi_ray_t   in_ray,
  output logic                out_v,
  output logic [DW-1:0]       out_disc,
  output rsi_pkg::rsi_side_t  out_side
);

  // stage 1
  logic v1_r;
  rsi_pkg::rsi_ray_t ray1_r;
  logic signed [32:0] dvx1_r, dvy1_r, dvz1_r;
  logic [61:0] rr1_r;
  // stage 2
  logic v2_r;
  rsi_pkg::rsi_ray_t ray2_r;
  logic signed [50:0] px2_r, py2_r, pz2_r;
  logic [63:0] qx2_r, qy2_r, qz2_r;
  logic [61:0] rr2_r;
  // stage 3
  logic v3_r;
  rsi_pkg::rsi_ray_t ray3_r;
  logic signed [rsi_pkg::H_W-1:0] h3_r;
  logic [65:0] sq3_r;
  logic [61:0] rr3_r;
  // stage 4
  logic v4_r;
  rsi_pkg::rsi_ray_t ray4_r;
  logic signed [rsi_pkg::H_W-1:0] h4_r;
  logic [53:0] pll4_r;
  logic [52:0] plh4_r;
  logic [51:0] phh4_r;
  logic ge4_r;
  logic [65:0] diff4_r;
  // stage 5
  logic v5_r;
  rsi_pkg::rsi_ray_t ray5_r;
  logic signed [rsi_pkg::H_W-1:0] h5_r;
  logic [DW-1:0] hh5_r, cs5_r;
  logic ge5_r;
  // stage 6
  logic v6_r;
  rsi_pkg::rsi_side_t side6_r;
  logic [DW-1:0] disc6_r;

  logic signed [65:0] sqx_full, sqy_full, sqz_full;
  logic [rsi_pkg::H_W-1:0] hm;

  assign sqx_full = dvx1_r * dvx1_r;
  assign sqy_full = dvy1_r * dvy1_r;
  assign sqz_full = dvz1_r * dvz1_r;
  assign hm = h3_r[rsi_pkg::H_W-1] ? rsi_pkg::H_W'(-h3_r) : rsi_pkg::H_W'(h3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1_r <= in_ray;
      dvx1_r <= {in_ray.o_x[31], in_ray.o_x} - {cfg.c_x[31], cfg.c_x};
      dvy1_r <= {in_ray.o_y[31], in_ray.o_y} - {cfg.c_y[31], cfg.c_y};
      dvz1_r <= {in_ray.o_z[31], in_ray.o_z} - {cfg.c_z[31], cfg.c_z};
      rr1_r  <= cfg.rad * cfg.rad;

      ray2_r <= ray1_r;
      px2_r  <= ray1_r.d_x * dvx1_r;
      py2_r  <= ray1_r.d_y * dvy1_r;
      pz2_r  <= ray1_r.d_z * dvz1_r;
      qx2_r  <= sqx_full[63:0];
      qy2_r  <= sqy_full[63:0];
      qz2_r  <= sqz_full[63:0];
      rr2_r  <= rr1_r;

      ray3_r <= ray2_r;
      h3_r   <= rsi_pkg::H_W'(px2_r) + rsi_pkg::H_W'(py2_r) + rsi_pkg::H_W'(pz2_r);
      sq3_r  <= 66'(qx2_r) + 66'(qy2_r) + 66'(qz2_r);
      rr3_r  <= rr2_r;

      // |h|^2 split into 27/26-bit halves
      ray4_r  <= ray3_r;
      h4_r    <= h3_r;
      pll4_r  <= hm[26:0] * hm[26:0];
      plh4_r  <= hm[26:0] * hm[52:27];
      phh4_r  <= hm[52:27] * hm[52:27];
      ge4_r   <= sq3_r >= 66'(rr3_r);
      diff4_r <= (sq3_r >= 66'(rr3_r)) ? sq3_r - 66'(rr3_r) : 66'(rr3_r) - sq3_r;

      ray5_r <= ray4_r;
      h5_r   <= h4_r;
      hh5_r  <= DW'(pll4_r) + (DW'(plh4_r) << 28) + (DW'(phh4_r) << 54);
      cs5_r  <= DW'(diff4_r) << (2 * FRAC_BITS);
      ge5_r  <= ge4_r;

      side6_r.ray <= ray5_r;
      side6_r.h   <= h5_r;
      if (ge5_r) begin
        side6_r.miss <= hh5_r < cs5_r;
        disc6_r      <= hh5_r - cs5_r;
      end else begin
        side6_r.miss <= 1'b0;
        disc6_r      <= hh5_r + cs5_r;
      end
    end
  end

  assign out_v    = v6_r;
  assign out_disc = disc6_r;
  assign out_side = side6_r;

endmodule

>>> hdl/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module rsi_sqrt #(
  parameter int DW = 106,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [DW-1:0]   in_rad,
  input  logic [PW-1:0]   in_sb,
  output logic            out_v,
  output logic [DW/2-1:0] out_root,
  output logic [PW-1:0]   out_sb
);

  localparam int SW = DW / 2;

  logic            v_r    [SW+1];
  logic [SW+1:0]   rem_r  [SW+1];
  logic [SW-1:0]   root_r [SW+1];
  logic [DW-1:0]   rad_r  [SW+1];
  logic [PW-1:0]   sb_r   [SW+1];

  assign v_r[0]    = in_v;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign rad_r[0]  = in_rad;
  assign sb_r[0]   = in_sb;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [SW+1:0] rem_sh, trial;
    logic          ge;

    // remainder stays below 2^SW, so the dropped top bits are zero
    assign rem_sh = {rem_r[k][SW-1:0], rad_r[k][DW-1:DW-2]};
    assign trial  = {root_r[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k+1] <= {root_r[k][SW-2:0], ge};
        rad_r[k+1]  <= rad_r[k] << 2;
        sb_r[k+1]   <= sb_r[k];
      end
    end
  end

  assign out_v    = v_r[SW];
  assign out_root = root_r[SW];
  assign out_sb   = sb_r[SW];

endmodule

>>> hdl/rsi_back.sv
// ----------------------------------------------------------------------------
// rsi_back
// Root selection, distance quantization and hit point, with saturation.
// ----------------------------------------------------------------------------
module rsi_back #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF,
  parameter int SW        = 53
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [SW-1:0]      in_s,
  input  rsi_pkg::rsi_side_t in_side,
  output logic               out_v,
  output logic               out_hit,
  output logic [30:0]        out_dist,
  output logic signed [31:0] out_px,
  output logic signed [31:0] out_py,
  output logic signed [31:0] out_pz
);

  localparam int TW = SW + 3;

  logic v7_r, hit7_r;
  rsi_pkg::rsi_ray_t ray7_r;
  logic [30:0] tq7_r;
  logic v8_r, hit8_r;
  rsi_pkg::rsi_ray_t ray8_r;
  logic [30:0] tq8_r;
  logic signed [49:0] prx8_r, pry8_r, prz8_r;
  logic v9_r, hit9_r;
  logic [30:0] dist9_r;
  logic signed [31:0] px9_r, py9_r, pz9_r;

  logic signed [TW-1:0] s_e, h_e, t_far, t_near, t_sel;
  logic sat_t;

  assign s_e    = $signed(TW'(in_s));
  assign h_e    = TW'(in_side.h);
  assign t_far  = s_e - h_e;
  assign t_near = -h_e - s_e;
  assign t_sel  = (t_near > 0) ? t_near : t_far;
  assign sat_t  = |t_sel[TW-1:FRAC_BITS+31];

  function automatic logic signed [31:0] pt_sat(input logic signed [31:0] o,
                                                input logic signed [49:0] pr);
    logic signed [50:0] sum;
    sum = 51'(o) + 51'(pr >>> FRAC_BITS);
    if (sum > 51'sd2147483647) begin
      pt_sat = 32'sh7FFFFFFF;
    end else if (sum < -51'sd2147483648) begin
      pt_sat = 32'sh80000000;
    end else begin
      pt_sat = sum[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (en) begin
      v7_r <= in_v;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray7_r <= in_side.ray;
      hit7_r <= !in_side.miss && (t_far > 0);
      tq7_r  <= sat_t ? 31'h7FFFFFFF : t_sel[FRAC_BITS+30:FRAC_BITS];

      ray8_r <= ray7_r;
      hit8_r <= hit7_r;
      tq8_r  <= tq7_r;
      prx8_r <= ray7_r.d_x * $signed({1'b0, tq7_r});
      pry8_r <= ray7_r.d_y * $signed({1'b0, tq7_r});
      prz8_r <= ray7_r.d_z * $signed({1'b0, tq7_r});

      hit9_r  <= hit8_r;
      dist9_r <= hit8_r ? tq8_r : '0;
      px9_r   <= hit8_r ? pt_sat(ray8_r.o_x, prx8_r) : '0;
      py9_r   <= hit8_r ? pt_sat(ray8_r.o_y, pry8_r) : '0;
      pz9_r   <= hit8_r ? pt_sat(ray8_r.o_z, prz8_r) : '0;
    end
  end

  assign out_v    = v9_r;
  assign out_hit  = hit9_r;
  assign out_dist = dist9_r;
  assign out_px   = px9_r;
  assign out_py   = py9_r;
  assign out_pz   = pz9_r;

endmodule

>>> hdl/ray_sphere_intersection.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// Fixed-point ray against one configured sphere, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one ray beat, origin and unit
//   direction in signed fixed point. Output channel (out_valid/out_stall):
//   one result beat per ray, in order: hit flag, distance, hit point.
//   Configuration (cfg_we/cfg_index/cfg_wdata): center x/y/z at indexes
//   0..2, radius at index 3; other indexes are ignored. Write only while
//   no ray is in flight.
//   Throughput: one ray per cycle while the output is not stalled. DW is
//   the discriminant width (106 bits at 16 fraction bits); the
//   bit-per-stage square root makes up most of the pipeline depth.
//   Reset clears every valid bit and loads center 0, radius 1.0.
//   A stall on the output with a result waiting freezes the whole pipeline
//   and raises in_stall in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_sphere_intersection #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [31:0]                 in_origin_x,
  input  logic signed [31:0]                 in_origin_y,
  input  logic signed [31:0]                 in_origin_z,
  input  logic signed [17:0]                 in_dir_x,
  input  logic signed [17:0]                 in_dir_y,
  input  logic signed [17:0]                 in_dir_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic [30:0]                        out_hit_distance,
  output logic signed [31:0]                 out_point_x,
  output logic signed [31:0]                 out_point_y,
  output logic signed [31:0]                 out_point_z
);

  localparam int DW = (2 * FRAC_BITS + 68 > 106) ? 2 * FRAC_BITS + 68 : 106;
  localparam int SW = DW / 2;
  localparam int PW = $bits(rsi_pkg::rsi_side_t);

  rsi_pkg::rsi_cfg_t cfg_r;
  rsi_pkg::rsi_ray_t ray;
  rsi_pkg::rsi_side_t f_side, b_side;
  logic en, f_v, s_v;
  logic [DW-1:0] f_disc;
  logic [SW-1:0] s_root;
  logic [PW-1:0] s_sb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_x <= '0;
      cfg_r.c_y <= '0;
      cfg_r.c_z <= '0;
      cfg_r.rad <= 31'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        rsi_pkg::REG_CENTER_X: cfg_r.c_x <= cfg_wdata;
        rsi_pkg::REG_CENTER_Y: cfg_r.c_y <= cfg_wdata;
        rsi_pkg::REG_CENTER_Z: cfg_r.c_z <= cfg_wdata;
        rsi_pkg::REG_RADIUS:   cfg_r.rad <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign ray.o_x = in_origin_x;
  assign ray.o_y = in_origin_y;
  assign ray.o_z = in_origin_z;
  assign ray.d_x = in_dir_x;
  assign ray.d_y = in_dir_y;
  assign ray.d_z = in_dir_z;

  rsi_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg_r),
    .in_v(in_valid), .in_ray(ray),
    .out_v(f_v), .out_disc(f_disc), .out_side(f_side)
  );

  rsi_sqrt #(.DW(DW), .PW(PW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(f_v), .in_rad(f_disc), .in_sb(f_side),
    .out_v(s_v), .out_root(s_root), .out_sb(s_sb)
  );

  assign b_side = rsi_pkg::rsi_side_t'(s_sb);

  rsi_back #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_back (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(s_v), .in_s(s_root), .in_side(b_side),
    .out_v(out_valid), .out_hit(out_hit), .out_dist(out_hit_distance),
    .out_px(out_point_x), .out_py(out_point_y), .out_pz(out_point_z)
  );

`ifndef NO_ASSERTIONS
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_distance == 31'd0 && out_point_x == 32'sd0
      && out_point_y == 32'sd0 && out_point_z == 32'sd0)
    else $error("nonzero fields on miss");
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_distance) && $stable(out_hit))
    else $error("pipeline moved under stall");
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output stall");
`endif

endmodule

>>> bench/tb_ray_sphere_intersection.sv
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersection
// Self-checking bench for the fixed-point ray/sphere pipeline. Rays are queued
// by a stimulus process, driven with random gaps and checked in order against
// an exact 128-bit predictor. The sphere is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersection;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam longint ONE = 64'd1 << FB;
  localparam logic [rsi_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd6;
  localparam logic [30:0] RAD_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic               hit;
    logic        [30:0] hit_dist;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } hit_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rsi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rsi_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [17:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [30:0] out_hit_distance;
  logic signed [31:0] out_point_x, out_point_y, out_point_z;

  ray_sphere_intersection #(.FRAC_BITS(FB)) u_top (.*);

  always #2 clk = ~clk;

  // sphere as currently programmed
  logic signed [31:0] sph_cx = '0, sph_cy = '0, sph_cz = '0;
  logic [30:0] sph_rad = 31'(ONE);

  rsi_pkg::rsi_ray_t ray_q[$];
  hit_res_t hit_q[$];
  int mismatches = 0;
  int results_seen = 0;
  bit steady = 1'b0;
  bit in_taken = 1'b0;

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic hit_res_t trace_ray(rsi_pkg::rsi_ray_t r);
    longint o[3], d[3], dv[3], h, tq;
    logic signed [127:0] w, sq, hh, rr, disc, s, cand, tfar, tnear, t;
    hit_res_t res;
    res = '0;
    o[0] = longint'($signed(r.o_x));
    o[1] = longint'($signed(r.o_y));
    o[2] = longint'($signed(r.o_z));
    d[0] = longint'($signed(r.d_x));
    d[1] = longint'($signed(r.d_y));
    d[2] = longint'($signed(r.d_z));
    dv[0] = o[0] - longint'(sph_cx);
    dv[1] = o[1] - longint'(sph_cy);
    dv[2] = o[2] - longint'(sph_cz);
    h = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      h += d[i] * dv[i];
      w = dv[i];
      sq += w * w;
    end
    w = h;
    hh = w * w;
    rr = 128'(sph_rad);
    rr = rr * rr;
    disc = hh - ((sq - rr) <<< (2 * FB));
    if (disc < 0) return res;
    s = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = s | (128'sd1 << b);
      if (cand * cand <= disc) s = cand;
    end
    tfar = s - w;
    tnear = -w - s;
    if (tfar <= 0) return res;
    t = (tnear > 0) ? tnear : tfar;
    t = t >>> FB;
    tq = (t > 128'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(t);
    res.hit = 1'b1;
    res.hit_dist = 31'(tq);
    res.px = 32'(clip32(o[0] + ((d[0] * tq) >>> FB)));
    res.py = 32'(clip32(o[1] + ((d[1] * tq) >>> FB)));
    res.pz = 32'(clip32(o[2] + ((d[2] * tq) >>> FB)));
    return res;
  endfunction

  // ray source: hold until taken, ~8% gaps unless in a steady stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (ray_q.size() > 0 && (steady || $urandom_range(0, 99) >= 8)) begin
        rsi_pkg::rsi_ray_t r;
        r = ray_q.pop_front();
        in_valid <= 1'b1;
        in_origin_x <= r.o_x;
        in_origin_y <= r.o_y;
        in_origin_z <= r.o_z;
        in_dir_x <= r.d_x;
        in_dir_y <= r.d_y;
        in_dir_z <= r.d_z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink: random stalls plus one long hold-off to back the pipe up
  int hold_left = 0;
  bit held = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!held && results_seen >= 300) begin
      held <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk) begin
    hit_res_t got, exp_r;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken)
      hit_q.push_back(trace_ray({in_origin_x, in_origin_y, in_origin_z,
                                 in_dir_x, in_dir_y, in_dir_z}));
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      got = {out_hit, out_hit_distance, out_point_x, out_point_y, out_point_z};
      if (hit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_r = hit_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch beat %0d: exp %p got %p", results_seen, exp_r, got);
        end
      end
    end
  end

  task automatic cfg_write(logic [rsi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rsi_pkg::REG_CENTER_X: sph_cx = val;
      rsi_pkg::REG_CENTER_Y: sph_cy = val;
      rsi_pkg::REG_CENTER_Z: sph_cz = val;
      rsi_pkg::REG_RADIUS:   sph_rad = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sphere(logic [31:0] cx, cy, cz, rad);
    cfg_write(rsi_pkg::REG_CENTER_X, cx);
    cfg_write(rsi_pkg::REG_CENTER_Y, cy);
    cfg_write(rsi_pkg::REG_CENTER_Z, cz);
    cfg_write(rsi_pkg::REG_RADIUS, rad);
  endtask

  task automatic add_ray(longint ox, oy, oz, dx, dy, dz);
    ray_q.push_back({32'(ox), 32'(oy), 32'(oz), 18'(dx), 18'(dy), 18'(dz)});
  endtask

  task automatic drain();
    while (ray_q.size() > 0 || in_valid || hit_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // mostly rays aimed near the sphere, a quarter pure noise
  task automatic add_random(int n);
    longint c[3], off[3], dd[3], span;
    int ax;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_ray($signed($urandom()), $signed($urandom()), $signed($urandom()),
                $urandom(), $urandom(), $urandom());
      end else begin
        c[0] = sph_cx; c[1] = sph_cy; c[2] = sph_cz;
        span = (longint'(sph_rad) + 1) * $urandom_range(1, 4);
        if (span > 64'sd2147483647) span = 64'sd2147483647;
        ax = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
          off[i] = longint'($urandom_range(0, 32'(2 * span))) - span;
          dd[i] = longint'($urandom_range(0, 60000)) - 30000;
        end
        dd[ax] = $urandom_range(40000, 65536);
        if (off[ax] > 0) dd[ax] = -dd[ax];
        add_ray(clip32(c[0] + off[0]), clip32(c[1] + off[1]),
                clip32(c[2] + off[2]), dd[0], dd[1], dd[2]);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset sphere: unit sphere at the origin
    add_ray(0, 0, -5 * ONE, 0, 0, ONE);          // near root
    add_ray(0, 0, 0, ONE, 0, 0);                 // inside: far root
    add_ray(0, 0, -5 * ONE, 0, 0, -ONE);         // pointing away
    add_ray(2 * ONE, 0, 0, 0, ONE, 0);           // clean miss
    add_ray(ONE, 0, -5 * ONE, 0, 0, ONE);        // grazing
    add_ray(ONE - 1, 0, 0, ONE, 0, 0);           // root exactly one lsb away
    add_ray(0, 0, -3 * ONE, 0, 0, ONE / 2);      // short direction
    add_ray(0, 0, -3 * ONE, 0, 0, 131071);       // over-long direction
    add_ray(0, 0, 3 * ONE, -65536, -131072, -65536);
    add_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, ONE, ONE, ONE);
    add_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, -ONE, -ONE, -ONE);
    add_ray(64'sd2147483647, 0, 0, -ONE, 0, 0);
    drain();

    set_sphere(32'(3 * ONE), 32'(-2 * ONE), 32'(ONE / 3), 32'(5 * ONE / 2));
    steady = 1'b1;
    add_random(150);
    drain();
    steady = 1'b0;
    add_random(300);
    drain();

    set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'(RAD_MAX));
    add_random(350);
    drain();

    set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
    add_random(350);
    drain();

    // point sphere; the spare index must not disturb anything
    set_sphere($urandom(), $urandom(), $urandom(), 32'h8000_0000);
    cfg_write(REG_SPARE, $urandom());
    add_random(300);
    drain();

    set_sphere($urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000, $urandom(),
               $urandom_range(0, 32'h00FF_FFFF), $urandom_range(1, 32'h00FF_FFFF));
    add_random(400);
    drain();

    repeat (100) @(posedge clk);
    if (mismatches == 0 && hit_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
